>>> rtl/qts_pkg.sv
// ----------------------------------------------------------------------------
// qts_pkg
// Shared types and constants for the two-stack queue.
// ----------------------------------------------------------------------------
package qts_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int VAL_W       = 32;
    localparam int STATUS_W    = 2;

    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_PUSH,
        OP_POP
    } t_stack_op;

    typedef struct packed {
        logic full;
        logic empty;
        logic last;
    } t_stack_stat;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_MOVE
    } t_state;

endpackage

>>> rtl/qts_cell.sv
// ----------------------------------------------------------------------------
// qts_cell
// One stack entry: loads from its shallower or deeper neighbour, or holds.
// ----------------------------------------------------------------------------
module qts_cell (
    input  logic                      i_clk,
    input  qts_pkg::t_stack_op        i_op,
    input  logic [qts_pkg::VAL_W-1:0] i_shallow,
    input  logic [qts_pkg::VAL_W-1:0] i_deep,
    output logic [qts_pkg::VAL_W-1:0] o_data
);

    logic [qts_pkg::VAL_W-1:0] r_data;
    logic [qts_pkg::VAL_W-1:0] n_data;

    always_comb begin
        case (i_op)
            qts_pkg::OP_PUSH: n_data = i_shallow;
            qts_pkg::OP_POP:  n_data = i_deep;
            default:          n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

>>> rtl/qts_stack.sv
// ----------------------------------------------------------------------------
// qts_stack
// Shift stack: a row of cells with the top in cell 0, plus a fill count.
// ----------------------------------------------------------------------------
module qts_stack (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  qts_pkg::t_stack_op        i_op,
    input  logic [qts_pkg::VAL_W-1:0] i_data,
    output logic [qts_pkg::VAL_W-1:0] o_top,
    output qts_pkg::t_stack_stat      o_stat
);

    logic [qts_pkg::VAL_W-1:0] w_cell [qts_pkg::STACK_DEPTH];
    logic [qts_pkg::CNT_W-1:0] r_count;
    logic [qts_pkg::CNT_W-1:0] n_count;

    for (genvar g = 0; g < qts_pkg::STACK_DEPTH; g++) begin : g_cell
        logic [qts_pkg::VAL_W-1:0] w_shallow;
        logic [qts_pkg::VAL_W-1:0] w_deep;

        if (g == 0) begin : g_top
            assign w_shallow = i_data;
        end else begin : g_mid
            assign w_shallow = w_cell[g-1];
        end

        if (g == qts_pkg::STACK_DEPTH - 1) begin : g_bot
            assign w_deep = w_cell[g];
        end else begin : g_inner
            assign w_deep = w_cell[g+1];
        end

        qts_cell u_cell (
            .i_clk     (i_clk),
            .i_op      (i_op),
            .i_shallow (w_shallow),
            .i_deep    (w_deep),
            .o_data    (w_cell[g])
        );
    end

    always_comb begin
        case (i_op)
            qts_pkg::OP_PUSH: n_count = r_count + 1'b1;
            qts_pkg::OP_POP:  n_count = r_count - 1'b1;
            default:          n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_top       = w_cell[0];
    assign o_stat.full  = (r_count == qts_pkg::CNT_W'(qts_pkg::STACK_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_stat.last  = (r_count == qts_pkg::CNT_W'(1));

endmodule

>>> rtl/queue_from_two_stacks.sv
// Sequence: an accepted item is registered, then executed into the result
// register; when the inbox is emptied onto the outbox, each entry is moved and
// the command is re-run; a stalled result register holds the execute step.
// A new item is taken only once the previous one has loaded its result; a move
// holds the control sequencer for its whole length.
// Reset: synchronous, active low; clears both fill counts, the sequencer and
// the output valid. Stack contents are not cleared.
// ----------------------------------------------------------------------------
// queue_from_two_stacks
// First-in first-out queue made of an inbox and an outbox shift stack.
// ----------------------------------------------------------------------------
module queue_from_two_stacks (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] value_in
    input  logic        s_axis_tuser,   // [0] command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] value_out, [32] queue_empty
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    qts_pkg::t_state                 r_state;
    qts_pkg::t_state                 n_state;
    logic                            r_cmd;
    logic [qts_pkg::VAL_W-1:0]       r_val;
    logic                            r_out_valid;
    logic [qts_pkg::STATUS_W-1:0]    r_status;
    logic [qts_pkg::VAL_W-1:0]       r_value;
    logic                            r_qempty;

    qts_pkg::t_stack_op              w_in_op;
    qts_pkg::t_stack_op              w_out_op;
    qts_pkg::t_stack_stat            w_in_stat;
    qts_pkg::t_stack_stat            w_out_stat;
    logic [qts_pkg::VAL_W-1:0]       w_in_top;
    logic [qts_pkg::VAL_W-1:0]       w_out_top;
    logic [qts_pkg::VAL_W-1:0]       w_out_din;
    logic                            w_accept;
    logic                            w_out_free;
    logic                            w_load;
    logic                            w_move;
    logic [qts_pkg::STATUS_W-1:0]    w_status;
    logic [qts_pkg::VAL_W-1:0]       w_value;
    logic                            w_qempty;

    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_out_valid || m_axis_tready;

    qts_stack u_inbox (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (w_in_op),
        .i_data  (r_val),
        .o_top   (w_in_top),
        .o_stat  (w_in_stat)
    );

    qts_stack u_outbox (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (w_out_op),
        .i_data  (w_out_din),
        .o_top   (w_out_top),
        .o_stat  (w_out_stat)
    );

    assign w_out_din = w_in_top;

    always_comb begin
        n_state = r_state;
        case (r_state)
            qts_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = qts_pkg::S_EXEC;
                end
            end
            qts_pkg::S_EXEC: begin
                if (w_load) begin
                    n_state = qts_pkg::S_IDLE;
                end else if (w_move) begin
                    n_state = qts_pkg::S_MOVE;
                end
            end
            qts_pkg::S_MOVE: begin
                if (w_in_stat.last) begin
                    n_state = qts_pkg::S_EXEC;
                end
            end
            default: n_state = qts_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = 1'b0;
        w_in_op       = qts_pkg::OP_HOLD;
        w_out_op      = qts_pkg::OP_HOLD;
        w_load        = 1'b0;
        w_move        = 1'b0;
        w_status      = qts_pkg::ST_OK;
        w_value       = '0;
        w_qempty      = 1'b0;
        case (r_state)
            qts_pkg::S_IDLE: begin
                s_axis_tready = 1'b1;
            end
            qts_pkg::S_EXEC: begin
                if (w_out_free) begin
                    if (r_cmd == qts_pkg::CMD_ENQ) begin
                        if (!w_in_stat.full) begin
                            w_in_op = qts_pkg::OP_PUSH;
                            w_load  = 1'b1;
                        end else if (w_out_stat.empty) begin
                            w_move = 1'b1;
                        end else begin
                            w_load   = 1'b1;
                            w_status = qts_pkg::ST_FULL;
                        end
                    end else begin
                        if (!w_out_stat.empty) begin
                            w_out_op = qts_pkg::OP_POP;
                            w_load   = 1'b1;
                            w_value  = w_out_top;
                            w_qempty = w_in_stat.empty && w_out_stat.last;
                        end else if (w_in_stat.empty) begin
                            w_load   = 1'b1;
                            w_status = qts_pkg::ST_EMPTY;
                            w_qempty = 1'b1;
                        end else begin
                            w_move = 1'b1;
                        end
                    end
                end
            end
            qts_pkg::S_MOVE: begin
                w_in_op  = qts_pkg::OP_POP;
                w_out_op = qts_pkg::OP_PUSH;
            end
            default: begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= qts_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= s_axis_tuser;
            r_val <= s_axis_tdata;
        end
        if (w_load) begin
            r_status <= w_status;
            r_value  <= w_value;
            r_qempty <= w_qempty;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_qempty, r_value};
    assign m_axis_tuser  = r_status;

endmodule

>>> rtl/qts_check.sv
// ----------------------------------------------------------------------------
// qts_check
// Port-level checks for the two-stack queue, bound to the top level.
// ----------------------------------------------------------------------------
module qts_check (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,
    input  logic        s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [39:0] m_axis_tdata,
    input  logic [1:0]  m_axis_tuser
);

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result item dropped while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    a_empty_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == qts_pkg::ST_EMPTY
            |-> m_axis_tdata[31:0] == 32'd0 && m_axis_tdata[32])
        else $error("refused dequeue must be zero with queue empty");

    a_full_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == qts_pkg::ST_FULL
            |-> m_axis_tdata[31:0] == 32'd0 && !m_axis_tdata[32])
        else $error("refused enqueue must be zero with queue not empty");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("item taken before the previous one finished");

endmodule

bind queue_from_two_stacks qts_check u_qts_check (.*);
